>>> sv/lfii_pkg.sv
package lfii_pkg;

  localparam int POSITION_WIDTH_DEFAULT   = 32;
  localparam int TICK_COUNT_WIDTH_DEFAULT = 16;

  localparam int CFG_ADDR_WIDTH = 5;

  typedef enum logic [2:0] {
    REG_FORK_TRIP_CURRENT   = 3'd0,
    REG_INTAKE_TRIP_CURRENT = 3'd1,
    REG_DEADBAND_LOW        = 3'd2,
    REG_DEADBAND_HIGH       = 3'd3,
    REG_LIFT_DOWN_SPEED     = 3'd4,
    REG_FORK_SPEED_IN       = 3'd5,
    REG_FORK_SPEED_OUT      = 3'd6,
    REG_TOP_HOLD_TICKS      = 3'd7
  } reg_idx_t;

  localparam logic [11:0]        FORK_TRIP_CURRENT_RST   = 12'd4095;
  localparam logic [11:0]        INTAKE_TRIP_CURRENT_RST = 12'd4095;
  localparam logic signed [15:0] DEADBAND_LOW_RST        = -16'sd3277;
  localparam logic signed [15:0] DEADBAND_HIGH_RST       = 16'sd3277;
  localparam logic [14:0]        LIFT_DOWN_SPEED_RST     = 15'd16384;
  localparam logic [14:0]        FORK_SPEED_IN_RST       = 15'd16384;
  localparam logic [14:0]        FORK_SPEED_OUT_RST      = 15'd16384;
  localparam logic [15:0]        TOP_HOLD_TICKS_RST      = 16'd50;

  localparam logic [14:0] Q15_POINT3 = 15'd9830;
  localparam logic [14:0] Q15_POINT7 = 15'd22938;
  localparam logic [14:0] Q15_HALF   = 15'd16384;
  localparam logic [14:0] Q15_MAX    = 15'd32767;

  localparam int BTN_INTAKE_ON  = 0;
  localparam int BTN_INTAKE_OFF = 1;
  localparam int BTN_FORK_IN    = 2;
  localparam int BTN_FORK_OUT   = 3;
  localparam int BTN_FORK_STOP  = 4;

  localparam int LIM_FORK_INNER = 0;
  localparam int LIM_FORK_OUTER = 1;
  localparam int LIM_LIFT_LOW   = 2;
  localparam int LIM_LIFT_HIGH  = 3;

  localparam logic MODE_MANUAL = 1'b0;
  localparam logic MODE_AUTO   = 1'b1;

endpackage

>>> sv/lift_fork_intake_interlock_core.sv
// Channel | Direction | Payload
// s_*     | in        | tuser: mode; tdata: buttons, limit_switches, stick_y,
//         |           |   lift_position, fork_current, left/right_intake_current
// m_*     | out       | tdata: intake_on, fork_drive, lift_drive, hold_enable,
//         |           |   hold_setpoint, forks_moving_in
// APB     | in/out    | eight configuration registers at 4*i
//
// One word per cycle sustained while the output is not stalled.
// Input register, then one pass of flag logic and a 15x15 constant multiply
// into the output register, which also updates the interlock state.
// Synchronous reset clears state, valids and registers to their reset values.
// A stalled output holds its word; the input register still drains into it
// whenever the output is empty or being taken.
module lift_fork_intake_interlock_core #(
  parameter int POSITION_WIDTH   = lfii_pkg::POSITION_WIDTH_DEFAULT,
  parameter int TICK_COUNT_WIDTH = lfii_pkg::TICK_COUNT_WIDTH_DEFAULT,
  localparam int IN_BITS  = 61 + POSITION_WIDTH,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 35 + POSITION_WIDTH,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // buttons, limit_switches, stick_y, lift_position, fork_current,
  // left_intake_current, right_intake_current, zero pad
  input  logic [IN_W-1:0]                     s_tdata,
  // mode
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // intake_on, fork_drive, lift_drive, hold_enable, hold_setpoint,
  // forks_moving_in, zero pad
  output logic [OUT_W-1:0]                    m_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lfii_pkg::CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int POS_LSB  = 25;
  localparam int FCUR_LSB = POS_LSB + POSITION_WIDTH;
  localparam int LCUR_LSB = FCUR_LSB + 12;
  localparam int RCUR_LSB = LCUR_LSB + 12;
  localparam int SET_LSB  = 34;
  localparam int MOVE_BIT = SET_LSB + POSITION_WIDTH;

  // configuration
  logic [11:0]        fork_trip_current;
  logic [11:0]        intake_trip_current;
  logic signed [15:0] deadband_low;
  logic signed [15:0] deadband_high;
  logic [14:0]        lift_down_speed;
  logic [14:0]        fork_speed_in;
  logic [14:0]        fork_speed_out;
  logic [15:0]        top_hold_ticks;
  lfii_pkg::reg_idx_t cfg_idx;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_idx   = lfii_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fork_trip_current   <= lfii_pkg::FORK_TRIP_CURRENT_RST;
      intake_trip_current <= lfii_pkg::INTAKE_TRIP_CURRENT_RST;
      deadband_low        <= lfii_pkg::DEADBAND_LOW_RST;
      deadband_high       <= lfii_pkg::DEADBAND_HIGH_RST;
      lift_down_speed     <= lfii_pkg::LIFT_DOWN_SPEED_RST;
      fork_speed_in       <= lfii_pkg::FORK_SPEED_IN_RST;
      fork_speed_out      <= lfii_pkg::FORK_SPEED_OUT_RST;
      top_hold_ticks      <= lfii_pkg::TOP_HOLD_TICKS_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        lfii_pkg::REG_FORK_TRIP_CURRENT:   fork_trip_current   <= pwdata[11:0];
        lfii_pkg::REG_INTAKE_TRIP_CURRENT: intake_trip_current <= pwdata[11:0];
        lfii_pkg::REG_DEADBAND_LOW:        deadband_low        <= pwdata[15:0];
        lfii_pkg::REG_DEADBAND_HIGH:       deadband_high       <= pwdata[15:0];
        lfii_pkg::REG_LIFT_DOWN_SPEED:     lift_down_speed     <= pwdata[14:0];
        lfii_pkg::REG_FORK_SPEED_IN:       fork_speed_in       <= pwdata[14:0];
        lfii_pkg::REG_FORK_SPEED_OUT:      fork_speed_out      <= pwdata[14:0];
        lfii_pkg::REG_TOP_HOLD_TICKS:      top_hold_ticks      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      lfii_pkg::REG_FORK_TRIP_CURRENT:   prdata = {20'd0, fork_trip_current};
      lfii_pkg::REG_INTAKE_TRIP_CURRENT: prdata = {20'd0, intake_trip_current};
      lfii_pkg::REG_DEADBAND_LOW:        prdata = {16'd0, deadband_low};
      lfii_pkg::REG_DEADBAND_HIGH:       prdata = {16'd0, deadband_high};
      lfii_pkg::REG_LIFT_DOWN_SPEED:     prdata = {17'd0, lift_down_speed};
      lfii_pkg::REG_FORK_SPEED_IN:       prdata = {17'd0, fork_speed_in};
      lfii_pkg::REG_FORK_SPEED_OUT:      prdata = {17'd0, fork_speed_out};
      lfii_pkg::REG_TOP_HOLD_TICKS:      prdata = {16'd0, top_hold_ticks};
      default:                           prdata = '0;
    endcase
  end

  // input register
  logic                 in_valid;
  logic [IN_BITS-1:0]   in_data;
  logic                 in_mode;
  logic                 advance;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata[IN_BITS-1:0];
      in_mode <= s_tuser;
    end
  end

  logic [4:0]                buttons;
  logic [3:0]                limits;
  logic signed [15:0]        stick_y;
  logic [POSITION_WIDTH-1:0] lift_position;
  logic [11:0]               fork_current;
  logic [11:0]               left_intake_current;
  logic [11:0]               right_intake_current;

  assign buttons              = in_data[4:0];
  assign limits               = in_data[8:5];
  assign stick_y              = in_data[24:9];
  assign lift_position        = in_data[POS_LSB +: POSITION_WIDTH];
  assign fork_current         = in_data[FCUR_LSB +: 12];
  assign left_intake_current  = in_data[LCUR_LSB +: 12];
  assign right_intake_current = in_data[RCUR_LSB +: 12];

  // interlock state
  logic                        intakes_running, intakes_running_next;
  logic                        fork_in_flag, fork_in_flag_next;
  logic                        fork_out_flag, fork_out_flag_next;
  logic signed [15:0]          fork_command, fork_command_next;
  logic                        top_lockout, top_lockout_next;
  logic [TICK_COUNT_WIDTH-1:0] top_tick_count, top_tick_count_next;
  logic                        hold_active, hold_active_next;
  logic [POSITION_WIDTH-1:0]   hold_position, hold_position_next;
  logic signed [15:0]          lift_drive;

  logic [29:0] up_product;
  logic [30:0] up_rounded;
  logic [16:0] up_sum;
  logic [14:0] up_drive;

  assign up_product = stick_y[14:0] * lfii_pkg::Q15_POINT7;
  assign up_rounded = {1'b0, up_product} + 31'(lfii_pkg::Q15_HALF);
  assign up_sum     = 17'(lfii_pkg::Q15_POINT3) + 17'(up_rounded[30:15]);
  assign up_drive   = (up_sum > 17'(lfii_pkg::Q15_MAX)) ? lfii_pkg::Q15_MAX : up_sum[14:0];

  always_comb begin
    intakes_running_next = intakes_running;
    fork_in_flag_next    = fork_in_flag;
    fork_out_flag_next   = fork_out_flag;
    fork_command_next    = fork_command;
    top_lockout_next     = top_lockout;
    top_tick_count_next  = top_tick_count;
    hold_active_next     = hold_active;
    hold_position_next   = hold_position;
    lift_drive           = '0;

    if (buttons[lfii_pkg::BTN_FORK_IN]) begin
      fork_in_flag_next  = 1'b1;
      fork_out_flag_next = 1'b0;
      fork_command_next  = -$signed({1'b0, fork_speed_in});
    end
    if (buttons[lfii_pkg::BTN_FORK_OUT]) begin
      fork_out_flag_next = 1'b1;
      fork_in_flag_next  = 1'b0;
      fork_command_next  = $signed({1'b0, fork_speed_out});
    end
    if (in_mode == lfii_pkg::MODE_MANUAL && buttons[lfii_pkg::BTN_FORK_STOP]) begin
      fork_in_flag_next  = 1'b0;
      fork_out_flag_next = 1'b0;
    end
    if (!fork_in_flag_next && !fork_out_flag_next) begin
      fork_command_next = '0;
    end
    if (in_mode == lfii_pkg::MODE_AUTO) begin
      if (fork_out_flag_next && limits[lfii_pkg::LIM_FORK_OUTER]) begin
        fork_out_flag_next = 1'b0;
      end else if (limits[lfii_pkg::LIM_FORK_INNER]) begin
        fork_in_flag_next = 1'b0;
      end
    end else begin
      if (limits[lfii_pkg::LIM_FORK_OUTER]) fork_out_flag_next = 1'b0;
      if (limits[lfii_pkg::LIM_FORK_INNER]) fork_in_flag_next = 1'b0;
    end
    if (fork_current > fork_trip_current) begin
      fork_command_next  = '0;
      fork_in_flag_next  = 1'b0;
      fork_out_flag_next = 1'b0;
    end

    if (in_mode == lfii_pkg::MODE_MANUAL) begin
      if (buttons[lfii_pkg::BTN_INTAKE_ON]) intakes_running_next = 1'b1;
      if (buttons[lfii_pkg::BTN_INTAKE_OFF]) intakes_running_next = 1'b0;
      if (left_intake_current > intake_trip_current ||
          right_intake_current > intake_trip_current) begin
        intakes_running_next = 1'b0;
      end

      if (limits[lfii_pkg::LIM_LIFT_HIGH]) begin
        top_lockout_next    = 1'b1;
        top_tick_count_next = '0;
      end else if (top_lockout && top_tick_count != '1) begin
        top_tick_count_next = top_tick_count + 1'b1;
      end
      if (top_lockout_next &&
          (32'(top_tick_count_next) > 32'(top_hold_ticks) || top_tick_count_next == '1)) begin
        top_lockout_next = 1'b0;
      end

      if (stick_y > deadband_low && stick_y < deadband_high) begin
        if (!hold_active) begin
          hold_position_next = lift_position;
          hold_active_next   = 1'b1;
        end
      end else begin
        hold_active_next = 1'b0;
        if (stick_y > 16'sd0 && !limits[lfii_pkg::LIM_LIFT_HIGH] && !top_lockout_next) begin
          lift_drive = $signed({1'b0, up_drive});
        end else if (stick_y < 16'sd0 && !limits[lfii_pkg::LIM_LIFT_LOW]) begin
          lift_drive = -$signed({1'b0, lift_down_speed});
        end
      end
    end
  end

  logic                 step;
  logic [OUT_W-1:0]     out_word;

  assign step = in_valid && advance;

  always_comb begin
    out_word                           = '0;
    out_word[0]                        = intakes_running_next;
    out_word[16:1]                     = fork_command_next;
    out_word[32:17]                    = lift_drive;
    out_word[33]                       = hold_active_next;
    out_word[SET_LSB +: POSITION_WIDTH] = hold_position_next;
    out_word[MOVE_BIT]                 = fork_in_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      intakes_running <= 1'b0;
      fork_in_flag    <= 1'b0;
      fork_out_flag   <= 1'b0;
      fork_command    <= '0;
      top_lockout     <= 1'b0;
      top_tick_count  <= '0;
      hold_active     <= 1'b0;
      hold_position   <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (step) begin
        intakes_running <= intakes_running_next;
        fork_in_flag    <= fork_in_flag_next;
        fork_out_flag   <= fork_out_flag_next;
        fork_command    <= fork_command_next;
        top_lockout     <= top_lockout_next;
        top_tick_count  <= top_tick_count_next;
        hold_active     <= hold_active_next;
        hold_position   <= hold_position_next;
      end
      if (advance) begin
        m_tvalid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= out_word;
    end
  end

endmodule

>>> sv/lfii_checker.sv
module lfii_checker #(
  parameter int POSITION_WIDTH = lfii_pkg::POSITION_WIDTH_DEFAULT,
  parameter int OUT_W          = 72
) (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  logic signed [15:0] fork_drive;
  logic signed [15:0] lift_drive;
  logic               hold_enable;
  logic               forks_moving_in;

  assign fork_drive      = m_tdata[16:1];
  assign lift_drive      = m_tdata[32:17];
  assign hold_enable     = m_tdata[33];
  assign forks_moving_in = m_tdata[34 + POSITION_WIDTH];

  a_reset_empties: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid straight after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed or dropped");

  a_inward_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && forks_moving_in |-> fork_drive <= 16'sd0)
    else $error("fork moving in with outward drive");

  a_hold_no_drive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && hold_enable |-> lift_drive == 16'sd0)
    else $error("lift driven while hold enabled");

  a_up_floor: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && lift_drive > 16'sd0 |-> lift_drive >= $signed({1'b0, lfii_pkg::Q15_POINT3}))
    else $error("upward lift drive below base level");

endmodule

bind lift_fork_intake_interlock_core lfii_checker #(
  .POSITION_WIDTH(POSITION_WIDTH),
  .OUT_W(OUT_W)
) u_lfii_checker (
  .clk(clk),
  .rst(rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);

>>> bench/lift_fork_intake_interlock_checker.sv
`timescale 1ns / 1ps

module lift_fork_intake_interlock_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  // buttons, limit_switches, stick_y, lift_position, fork_current,
  // left_intake_current, right_intake_current, zero pad
  input  logic [95:0]                         s_tdata,
  // mode
  input  logic                                s_tuser,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  // intake_on, fork_drive, lift_drive, hold_enable, hold_setpoint,
  // forks_moving_in, zero pad
  input  logic [71:0]                         m_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [lfii_pkg::CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                         pwdata,
  output int                                  errors,
  output int                                  pending,
  output int                                  checked
);

  typedef struct packed {
    logic [11:0]        right_cur;
    logic [11:0]        left_cur;
    logic [11:0]        fork_cur;
    logic signed [31:0] pos;
    logic signed [15:0] stick;
    logic [3:0]         lim;
    logic [4:0]         btn;
  } sample_t;

  typedef struct packed {
    logic               moving_in;
    logic signed [31:0] setpoint;
    logic               hold_en;
    logic signed [15:0] lift;
    logic signed [15:0] fork_drv;
    logic               intake;
  } result_t;

  logic [11:0]        fork_lim;
  logic [11:0]        intake_lim;
  logic signed [15:0] db_lo;
  logic signed [15:0] db_hi;
  logic [14:0]        down_spd;
  logic [14:0]        spd_in;
  logic [14:0]        spd_out;
  logic [15:0]        hold_ticks;

  logic               intake_run;
  logic               fin;
  logic               fout;
  logic signed [15:0] fork_cmd;
  logic               lockout;
  logic [15:0]        ticks;
  logic               holding;
  logic [31:0]        hold_pos;

  result_t due_q[$];

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  task automatic set_reg(input lfii_pkg::reg_idx_t idx, input logic [31:0] val);
    case (idx)
      lfii_pkg::REG_FORK_TRIP_CURRENT:   fork_lim   = val[11:0];
      lfii_pkg::REG_INTAKE_TRIP_CURRENT: intake_lim = val[11:0];
      lfii_pkg::REG_DEADBAND_LOW:        db_lo      = val[15:0];
      lfii_pkg::REG_DEADBAND_HIGH:       db_hi      = val[15:0];
      lfii_pkg::REG_LIFT_DOWN_SPEED:     down_spd   = val[14:0];
      lfii_pkg::REG_FORK_SPEED_IN:       spd_in     = val[14:0];
      lfii_pkg::REG_FORK_SPEED_OUT:      spd_out    = val[14:0];
      lfii_pkg::REG_TOP_HOLD_TICKS:      hold_ticks = val[15:0];
      default: ;
    endcase
  endtask

  task automatic start_in();
    fin      = 1'b1;
    fout     = 1'b0;
    fork_cmd = -$signed({1'b0, spd_in});
  endtask

  task automatic start_out();
    fout     = 1'b1;
    fin      = 1'b0;
    fork_cmd = $signed({1'b0, spd_out});
  endtask

  task automatic fork_trip(input logic [11:0] cur);
    if (cur > fork_lim) begin
      fork_cmd = '0;
      fin      = 1'b0;
      fout     = 1'b0;
    end
  endtask

  task automatic step_lift(input sample_t w, input logic mode_bit, output result_t r);
    logic signed [15:0] lift;
    int                 up;
    lift = '0;
    if (mode_bit == lfii_pkg::MODE_AUTO) begin
      if (w.btn[lfii_pkg::BTN_FORK_IN]) start_in();
      if (w.btn[lfii_pkg::BTN_FORK_OUT]) start_out();
      if (!fin && !fout) fork_cmd = '0;
      if (fout && w.lim[lfii_pkg::LIM_FORK_OUTER]) fout = 1'b0;
      else if (w.lim[lfii_pkg::LIM_FORK_INNER]) fin = 1'b0;
      fork_trip(w.fork_cur);
    end else begin
      if (w.btn[lfii_pkg::BTN_INTAKE_ON]) intake_run = 1'b1;
      if (w.btn[lfii_pkg::BTN_INTAKE_OFF]) intake_run = 1'b0;
      if (w.left_cur > intake_lim || w.right_cur > intake_lim) intake_run = 1'b0;

      if (w.btn[lfii_pkg::BTN_FORK_IN]) start_in();
      if (w.btn[lfii_pkg::BTN_FORK_OUT]) start_out();
      if (w.btn[lfii_pkg::BTN_FORK_STOP]) begin
        fin  = 1'b0;
        fout = 1'b0;
      end
      if (!fin && !fout) fork_cmd = '0;
      if (w.lim[lfii_pkg::LIM_FORK_OUTER]) fout = 1'b0;
      if (w.lim[lfii_pkg::LIM_FORK_INNER]) fin = 1'b0;
      fork_trip(w.fork_cur);

      if (w.lim[lfii_pkg::LIM_LIFT_HIGH]) begin
        lockout = 1'b1;
        ticks   = '0;
      end else if (lockout && ticks != 16'hFFFF) begin
        ticks = ticks + 16'd1;
      end
      if (lockout && (ticks > hold_ticks || ticks == 16'hFFFF)) lockout = 1'b0;

      if (w.stick > db_lo && w.stick < db_hi) begin
        if (!holding) begin
          hold_pos = w.pos;
          holding  = 1'b1;
        end
      end else begin
        holding = 1'b0;
        if (w.stick > 0 && !w.lim[lfii_pkg::LIM_LIFT_HIGH] && !lockout) begin
          up   = int'(w.stick) * int'(lfii_pkg::Q15_POINT7) + int'(lfii_pkg::Q15_HALF);
          up   = int'(lfii_pkg::Q15_POINT3) + (up >>> 15);
          lift = (up > int'(lfii_pkg::Q15_MAX)) ? $signed({1'b0, lfii_pkg::Q15_MAX})
                                                : 16'(up);
        end else if (w.stick < 0 && !w.lim[lfii_pkg::LIM_LIFT_LOW]) begin
          lift = -$signed({1'b0, down_spd});
        end
      end
    end
    r.intake    = intake_run;
    r.fork_drv  = fork_cmd;
    r.lift      = lift;
    r.hold_en   = holding;
    r.setpoint  = hold_pos;
    r.moving_in = fin;
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    result_t nxt;
    if (rst) begin
      fork_lim   = lfii_pkg::FORK_TRIP_CURRENT_RST;
      intake_lim = lfii_pkg::INTAKE_TRIP_CURRENT_RST;
      db_lo      = lfii_pkg::DEADBAND_LOW_RST;
      db_hi      = lfii_pkg::DEADBAND_HIGH_RST;
      down_spd   = lfii_pkg::LIFT_DOWN_SPEED_RST;
      spd_in     = lfii_pkg::FORK_SPEED_IN_RST;
      spd_out    = lfii_pkg::FORK_SPEED_OUT_RST;
      hold_ticks = lfii_pkg::TOP_HOLD_TICKS_RST;
      intake_run = 1'b0;
      fin        = 1'b0;
      fout       = 1'b0;
      fork_cmd   = '0;
      lockout    = 1'b0;
      ticks      = '0;
      holding    = 1'b0;
      hold_pos   = '0;
      due_q.delete();
    end else begin
      if (psel && penable && pwrite && pready)
        set_reg(lfii_pkg::reg_idx_t'(paddr[4:2]), pwdata);
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[66:0]);
        if (due_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = due_q.pop_front();
          checked++;
          if (got.intake !== want.intake) begin
            $display("%0t: intake_on expected %0d actual %0d", $time, want.intake, got.intake);
            errors++;
          end
          if (got.fork_drv !== want.fork_drv) begin
            $display("%0t: fork_drive expected %0d actual %0d", $time,
                     want.fork_drv, got.fork_drv);
            errors++;
          end
          if (got.lift !== want.lift) begin
            $display("%0t: lift_drive expected %0d actual %0d", $time, want.lift, got.lift);
            errors++;
          end
          if (got.hold_en !== want.hold_en) begin
            $display("%0t: hold_enable expected %0d actual %0d", $time,
                     want.hold_en, got.hold_en);
            errors++;
          end
          if (got.setpoint !== want.setpoint) begin
            $display("%0t: hold_setpoint expected %0d actual %0d", $time,
                     want.setpoint, got.setpoint);
            errors++;
          end
          if (got.moving_in !== want.moving_in) begin
            $display("%0t: forks_moving_in expected %0d actual %0d", $time,
                     want.moving_in, got.moving_in);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        step_lift(sample_t'(s_tdata[92:0]), s_tuser, nxt);
        due_q.push_back(nxt);
      end
    end
    pending = due_q.size();
  end

endmodule

>>> bench/lift_fork_intake_interlock_core_tb.sv
`timescale 1ns / 1ps

module lift_fork_intake_interlock_core_tb;

  localparam int CYCLE_LIMIT = 600000;
  localparam int LOCKOUT_RUN = 30;

  localparam logic [4:0] B_ON   = 5'(1 << lfii_pkg::BTN_INTAKE_ON);
  localparam logic [4:0] B_OFF  = 5'(1 << lfii_pkg::BTN_INTAKE_OFF);
  localparam logic [4:0] B_IN   = 5'(1 << lfii_pkg::BTN_FORK_IN);
  localparam logic [4:0] B_OUT  = 5'(1 << lfii_pkg::BTN_FORK_OUT);
  localparam logic [4:0] B_STOP = 5'(1 << lfii_pkg::BTN_FORK_STOP);
  localparam logic [3:0] L_INNER = 4'(1 << lfii_pkg::LIM_FORK_INNER);
  localparam logic [3:0] L_OUTER = 4'(1 << lfii_pkg::LIM_FORK_OUTER);
  localparam logic [3:0] L_LOW   = 4'(1 << lfii_pkg::LIM_LIFT_LOW);
  localparam logic [3:0] L_HIGH  = 4'(1 << lfii_pkg::LIM_LIFT_HIGH);

  typedef struct packed {
    logic [11:0]        right_cur;
    logic [11:0]        left_cur;
    logic [11:0]        fork_cur;
    logic signed [31:0] pos;
    logic signed [15:0] stick;
    logic [3:0]         lim;
    logic [4:0]         btn;
  } sample_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [lfii_pkg::CFG_ADDR_WIDTH-1:0] paddr = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int pending;
  int checked;
  int cycles   = 0;
  int words_in = 0;
  int writes   = 0;
  int gap_pct  = 20;
  int rx_pct   = 20;
  bit quiet    = 1'b0;

  logic [31:0] cfg_now [8];
  logic [31:0] cfg_set [8];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  lift_fork_intake_interlock_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  lift_fork_intake_interlock_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked)
  );

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped at the cycle limit with %0d words outstanding", pending);
    $display("FAILURE");
    $finish;
  end

  // stall the output side in bursts
  initial begin
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 99) < rx_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  task automatic push_word(input logic mode_bit, input sample_t w);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    s_tuser  <= mode_bit;
    s_tdata  <= {3'b000, w};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    words_in++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input lfii_pkg::reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    cfg_now[idx] = val;
    writes++;
  endtask

  task automatic load_cfg();
    for (int i = 0; i < 8; i++) write_reg(lfii_pkg::reg_idx_t'(i), cfg_set[i]);
  endtask

  function automatic sample_t mk(input logic [4:0] btn, input logic [3:0] lim,
                                 input logic signed [15:0] stick,
                                 input logic signed [31:0] pos,
                                 input logic [11:0] fc, input logic [11:0] lc,
                                 input logic [11:0] rc);
    sample_t w;
    w.btn       = btn;
    w.lim       = lim;
    w.stick     = stick;
    w.pos       = pos;
    w.fork_cur  = fc;
    w.left_cur  = lc;
    w.right_cur = rc;
    return w;
  endfunction

  function automatic logic [11:0] pick_current(input logic [11:0] lim);
    case ($urandom_range(0, 9))
      0: return 12'hFFF;
      1: return 12'h000;
      2: return lim;
      3: return (lim == 12'hFFF) ? lim : lim + 12'd1;
      default: return 12'($urandom_range(0, lim));
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t            w;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    lo = cfg_now[lfii_pkg::REG_DEADBAND_LOW][15:0];
    hi = cfg_now[lfii_pkg::REG_DEADBAND_HIGH][15:0];
    for (int k = 0; k < 5; k++)
      w.btn[k] = ($urandom_range(0, (k == lfii_pkg::BTN_FORK_STOP) ? 7 : 3) == 0);
    w.lim[lfii_pkg::LIM_FORK_INNER] = ($urandom_range(0, 5) == 0);
    w.lim[lfii_pkg::LIM_FORK_OUTER] = ($urandom_range(0, 5) == 0);
    w.lim[lfii_pkg::LIM_LIFT_LOW]   = ($urandom_range(0, 5) == 0);
    w.lim[lfii_pkg::LIM_LIFT_HIGH]  = ($urandom_range(0, 63) == 0);
    case ($urandom_range(0, 11))
      0: w.stick = 16'sh7FFF;
      1: w.stick = 16'sh8000;
      2: w.stick = '0;
      3: w.stick = lo;
      4: w.stick = lo + 16'sd1;
      5: w.stick = hi;
      6: w.stick = hi - 16'sd1;
      7: w.stick = 16'($urandom_range(0, 8000)) - 16'sd4000;
      default: w.stick = 16'($urandom);
    endcase
    if ($urandom_range(0, 7) == 0)
      w.pos = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
    else
      w.pos = $urandom;
    w.fork_cur  = pick_current(cfg_now[lfii_pkg::REG_FORK_TRIP_CURRENT][11:0]);
    w.left_cur  = pick_current(cfg_now[lfii_pkg::REG_INTAKE_TRIP_CURRENT][11:0]);
    w.right_cur = pick_current(cfg_now[lfii_pkg::REG_INTAKE_TRIP_CURRENT][11:0]);
    return w;
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++)
      push_word(($urandom_range(0, 9) < 3) ? lfii_pkg::MODE_AUTO : lfii_pkg::MODE_MANUAL,
                rand_sample());
  endtask

  task automatic random_cfg(input int tick_max);
    cfg_set[lfii_pkg::REG_FORK_TRIP_CURRENT]   = $urandom_range(0, 4095);
    cfg_set[lfii_pkg::REG_INTAKE_TRIP_CURRENT] = $urandom_range(0, 4095);
    cfg_set[lfii_pkg::REG_DEADBAND_LOW]        = 32'($urandom_range(0, 12000)) - 32'd9000;
    cfg_set[lfii_pkg::REG_DEADBAND_HIGH]       = 32'($urandom_range(0, 12000)) - 32'd3000;
    cfg_set[lfii_pkg::REG_LIFT_DOWN_SPEED]     = $urandom_range(0, 32767);
    cfg_set[lfii_pkg::REG_FORK_SPEED_IN]       = $urandom_range(0, 32767);
    cfg_set[lfii_pkg::REG_FORK_SPEED_OUT]      = $urandom_range(0, 32767);
    cfg_set[lfii_pkg::REG_TOP_HOLD_TICKS]      = $urandom_range(0, tick_max);
  endtask

  initial begin : stimulus
    sample_t w;
    cfg_now[lfii_pkg::REG_FORK_TRIP_CURRENT]   = 32'(lfii_pkg::FORK_TRIP_CURRENT_RST);
    cfg_now[lfii_pkg::REG_INTAKE_TRIP_CURRENT] = 32'(lfii_pkg::INTAKE_TRIP_CURRENT_RST);
    cfg_now[lfii_pkg::REG_DEADBAND_LOW]        = 32'(lfii_pkg::DEADBAND_LOW_RST);
    cfg_now[lfii_pkg::REG_DEADBAND_HIGH]       = 32'(lfii_pkg::DEADBAND_HIGH_RST);
    cfg_now[lfii_pkg::REG_LIFT_DOWN_SPEED]     = 32'(lfii_pkg::LIFT_DOWN_SPEED_RST);
    cfg_now[lfii_pkg::REG_FORK_SPEED_IN]       = 32'(lfii_pkg::FORK_SPEED_IN_RST);
    cfg_now[lfii_pkg::REG_FORK_SPEED_OUT]      = 32'(lfii_pkg::FORK_SPEED_OUT_RST);
    cfg_now[lfii_pkg::REG_TOP_HOLD_TICKS]      = 32'(lfii_pkg::TOP_HOLD_TICKS_RST);
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset settings
    push_word(lfii_pkg::MODE_MANUAL, mk('0, '0, 16'sd0, 32'sd1234, 12'd0, 12'd0, 12'd0));
    push_word(lfii_pkg::MODE_MANUAL, mk(B_ON, '0, 16'sd0, 32'sd99, 12'd0, 12'd0, 12'd0));
    push_word(lfii_pkg::MODE_MANUAL, mk(B_ON | B_OFF, '0, 16'sd0, 32'sd0, 12'd0, 12'd0,
                                        12'd0));
    push_word(lfii_pkg::MODE_MANUAL, mk(B_ON | B_IN, '0, 16'sd0, 32'sd0, 12'd0, 12'd4095,
                                        12'd4095));
    push_word(lfii_pkg::MODE_MANUAL, mk('0, L_INNER, 16'sd0, 32'sd0, 12'd0, 12'd0, 12'd0));
    push_word(lfii_pkg::MODE_MANUAL, mk('0, '0, 16'sd0, 32'sd0, 12'd0, 12'd0, 12'd0));
    push_word(lfii_pkg::MODE_MANUAL, mk(B_IN | B_OUT, '0, 16'sd0, 32'sd0, 12'd4095, 12'd0,
                                        12'd0));
    push_word(lfii_pkg::MODE_MANUAL, mk(B_OUT | B_STOP, '0, 16'sd0, 32'sd0, 12'd0, 12'd0,
                                        12'd0));
    push_word(lfii_pkg::MODE_MANUAL, mk(B_OUT, L_OUTER, 16'sd0, 32'sd0, 12'd0, 12'd0,
                                        12'd0));
    push_word(lfii_pkg::MODE_MANUAL, mk('0, '0, 16'sh7FFF, 32'sd5, 12'd0, 12'd0, 12'd0));
    push_word(lfii_pkg::MODE_MANUAL, mk('0, '0, 16'sh8000, 32'sd6, 12'd0, 12'd0, 12'd0));
    push_word(lfii_pkg::MODE_MANUAL, mk('0, L_LOW, 16'sh8000, 32'sd7, 12'd0, 12'd0, 12'd0));
    push_word(lfii_pkg::MODE_MANUAL, mk('0, L_HIGH, 16'sh7FFF, 32'sd8, 12'd0, 12'd0,
                                        12'd0));
    push_word(lfii_pkg::MODE_MANUAL, mk('0, '0, 16'sh7FFF, 32'sd9, 12'd0, 12'd0, 12'd0));
    push_word(lfii_pkg::MODE_AUTO, mk(B_ON | B_STOP | B_IN, '0, 16'sh7FFF, 32'sd10, 12'd0,
                                      12'd0, 12'd0));
    push_word(lfii_pkg::MODE_AUTO, mk(B_OUT, L_OUTER | L_INNER, 16'sd0, 32'sd0, 12'd0,
                                      12'd0, 12'd0));
    push_word(lfii_pkg::MODE_AUTO, mk(B_IN, L_INNER, 16'sd0, 32'sd0, 12'd0, 12'd0, 12'd0));
    push_word(lfii_pkg::MODE_AUTO, mk(5'h1F, 4'hF, 16'sh8000, 32'sh7FFFFFFF, 12'hFFF,
                                      12'hFFF, 12'hFFF));
    push_word(lfii_pkg::MODE_MANUAL, mk(5'h1F, 4'hF, 16'sh7FFF, 32'sh80000000, 12'hFFF,
                                        12'hFFF, 12'hFFF));
    push_word(lfii_pkg::MODE_MANUAL, mk(B_OUT, '0, -16'sd3277, 32'sd11, 12'd0, 12'd0,
                                        12'd0));
    push_word(lfii_pkg::MODE_MANUAL, mk('0, '0, -16'sd3276, 32'sd12, 12'd0, 12'd0, 12'd0));
    push_word(lfii_pkg::MODE_MANUAL, mk('0, '0, 16'sd3277, 32'sd13, 12'd0, 12'd0, 12'd0));
    push_word(lfii_pkg::MODE_MANUAL, mk('0, '0, 16'sd3276, 32'sd14, 12'd0, 12'd0, 12'd0));
    run_random(300);
    drain();

    // lowest trip currents, speeds and top hold, widest deadband
    cfg_set[lfii_pkg::REG_FORK_TRIP_CURRENT]   = 0;
    cfg_set[lfii_pkg::REG_INTAKE_TRIP_CURRENT] = 0;
    cfg_set[lfii_pkg::REG_DEADBAND_LOW]        = 32'hFFFF8000;
    cfg_set[lfii_pkg::REG_DEADBAND_HIGH]       = 32'h00007FFF;
    cfg_set[lfii_pkg::REG_LIFT_DOWN_SPEED]     = 0;
    cfg_set[lfii_pkg::REG_FORK_SPEED_IN]       = 0;
    cfg_set[lfii_pkg::REG_FORK_SPEED_OUT]      = 0;
    cfg_set[lfii_pkg::REG_TOP_HOLD_TICKS]      = 0;
    load_cfg();
    gap_pct = 30;
    rx_pct  = 10;
    run_random(300);
    drain();

    // highest currents and speeds, empty deadband, short top hold
    cfg_set[lfii_pkg::REG_FORK_TRIP_CURRENT]   = 4095;
    cfg_set[lfii_pkg::REG_INTAKE_TRIP_CURRENT] = 4095;
    cfg_set[lfii_pkg::REG_DEADBAND_LOW]        = 32'h00007FFF;
    cfg_set[lfii_pkg::REG_DEADBAND_HIGH]       = 32'hFFFF8000;
    cfg_set[lfii_pkg::REG_LIFT_DOWN_SPEED]     = 32767;
    cfg_set[lfii_pkg::REG_FORK_SPEED_IN]       = 32767;
    cfg_set[lfii_pkg::REG_FORK_SPEED_OUT]      = 32767;
    cfg_set[lfii_pkg::REG_TOP_HOLD_TICKS]      = 3;
    load_cfg();
    gap_pct = 10;
    rx_pct  = 35;
    run_random(300);
    drain();

    random_cfg(40);
    load_cfg();
    gap_pct = 0;
    rx_pct  = 0;
    run_random(300);
    drain();

    random_cfg(12);
    load_cfg();
    gap_pct = 25;
    rx_pct  = 25;
    run_random(300);
    drain();

    // longest lockout setting: hold the lockout through a short run
    write_reg(lfii_pkg::REG_TOP_HOLD_TICKS, 32'hFFFF);
    quiet = 1'b1;
    push_word(lfii_pkg::MODE_MANUAL, mk('0, L_HIGH, 16'sh7FFF, 32'sd0, 12'd0, 12'd0, 12'd0));
    for (int i = 0; i < LOCKOUT_RUN; i++) begin
      w = rand_sample();
      w.lim[lfii_pkg::LIM_LIFT_HIGH] = 1'b0;
      push_word(lfii_pkg::MODE_MANUAL, w);
    end
    drain();
    quiet = 1'b0;

    cfg_set[lfii_pkg::REG_FORK_TRIP_CURRENT]   = 32'(lfii_pkg::FORK_TRIP_CURRENT_RST)
                                                 - 32'd1000;
    cfg_set[lfii_pkg::REG_INTAKE_TRIP_CURRENT] = 32'(lfii_pkg::INTAKE_TRIP_CURRENT_RST)
                                                 - 32'd1000;
    cfg_set[lfii_pkg::REG_DEADBAND_LOW]        = 32'(lfii_pkg::DEADBAND_LOW_RST);
    cfg_set[lfii_pkg::REG_DEADBAND_HIGH]       = 32'(lfii_pkg::DEADBAND_HIGH_RST);
    cfg_set[lfii_pkg::REG_LIFT_DOWN_SPEED]     = 32'(lfii_pkg::LIFT_DOWN_SPEED_RST);
    cfg_set[lfii_pkg::REG_FORK_SPEED_IN]       = 32'(lfii_pkg::FORK_SPEED_IN_RST);
    cfg_set[lfii_pkg::REG_FORK_SPEED_OUT]      = 32'(lfii_pkg::FORK_SPEED_OUT_RST);
    cfg_set[lfii_pkg::REG_TOP_HOLD_TICKS]      = 32'(lfii_pkg::TOP_HOLD_TICKS_RST);
    load_cfg();
    gap_pct = 20;
    rx_pct  = 20;
    run_random(200);
    quiet = 1'b1;
    run_random(150);
    drain();
    repeat (10) @(negedge clk);

    $display("Sent %0d words across seven register settings with %0d register writes,",
             words_in, writes);
    $display("including the longest lockout setting; %0d results checked, %0d mismatches.",
             checked, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
sv/lfii_pkg.sv
sv/lift_fork_intake_interlock_core.sv
sv/lfii_checker.sv
bench/lift_fork_intake_interlock_checker.sv
bench/lift_fork_intake_interlock_core_tb.sv
